@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is high.
`define PSD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("psd assertion failed");

// Same, with a caller supplied message.
`define PSD_ASSERT_MSG(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

`endif

@@ rtl/core/psd_pkg.sv @@
`timescale 1ns / 1ps

package psd_pkg;

   // result kinds
   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } psd_kind_type;

   // parser phases, one-hot
   typedef enum logic [3:0] {
      PH_GLOBAL  = 4'b0001,
      PH_RECHDR  = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_HALT    = 4'b1000
   } psd_phase_type;

   localparam logic [31:0] MAGIC_US_NATIVE  = 32'hA1B2_C3D4;
   localparam logic [31:0] MAGIC_US_SWAPPED = 32'hD4C3_B2A1;
   localparam logic [31:0] MAGIC_NS_NATIVE  = 32'hA1B2_3C4D;
   localparam logic [31:0] MAGIC_NS_SWAPPED = 32'h4D3C_B2A1;

   localparam logic [4:0] GLOBAL_LAST_BYTE = 5'd23;
   localparam logic [3:0] RECHDR_LAST_BYTE = 4'd15;

   localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
   localparam logic [9:0]  NS_PER_US  = 10'd1000;

   localparam int PSD_QUEUE_DEPTH = 4;

   // one unit of work handed from the parser to the result path
   typedef struct packed {
      psd_kind_type kind;
      logic [31:0]  ts_sec;
      logic [31:0]  ts_frac;
      logic         nano;
      logic [31:0]  wire_length;
      logic [31:0]  captured_length;
      logic [7:0]   payload_byte;
      logic         last;
   } psd_entry_type;

   function automatic logic [31:0] flip32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

@@ rtl/core/psd_if.sv @@
`timescale 1ns / 1ps

interface psd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       restart;

   modport source (output valid, output stream_byte, output restart, input ready);
   modport sink   (input valid, input stream_byte, input restart, output ready);
endinterface

interface psd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] time_ns;
   logic [31:0] wire_length;
   logic [31:0] captured_length;
   logic [7:0]  payload_byte;
   logic        last;

   modport source (output valid, output kind, output time_ns, output wire_length,
                   output captured_length, output payload_byte, output last,
                   input ready);
   modport sink   (input valid, input kind, input time_ns, input wire_length,
                   input captured_length, input payload_byte, input last,
                   output ready);
endinterface

@@ rtl/core/pcap_stream_deframer_unit.sv @@
`timescale 1ns / 1ps

// channel   | dir | payload                                          | taken when
// ----------+-----+--------------------------------------------------+--------------
// req_ch    | in  | stream_byte, restart                             | valid & ready
// rsp_ch    | out | kind, time_ns, wire_length, captured_length,     | valid & ready
//           |     | payload_byte, last                               |
//
// One byte per cycle while the queue has room; the parser decides each byte in the cycle
// it is taken. A result passes from the queue, written on the edge that takes its byte,
// through the multiply stage, then the add into the output register. Throughput is set
// by the parser register update, one byte per clock while the queue is not full.
// reset is synchronous, clears the parser and empties queue and pipeline; no clearing pass.
// req_ch.ready drops only while the queue is full; rsp_ch stalls back up into the queue.

module pcap_stream_deframer_unit
   import psd_pkg::*;
#(
   parameter int QUEUE_DEPTH = PSD_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   psd_req_if.sink   req_ch,
   psd_rsp_if.source rsp_ch
);

   // front to queue
   logic          f_push;
   psd_entry_type f_entry;
   logic          q_full;

   // queue to back
   logic          q_valid;
   psd_entry_type q_entry;
   logic          q_pop;

   // parser: header collection, magic check, byte swap, payload count
   psd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .push   (f_push),
      .entry  (f_entry)
   );

   // decouples the parser from output stalls
   psd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_push),
      .push_entry (f_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   // timestamp to nanoseconds, then the output register
   psd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

@@ rtl/core/psd_queue.sv @@
`timescale 1ns / 1ps

module psd_queue
   import psd_pkg::*;
#(
   parameter int DEPTH = PSD_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  psd_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          pop_valid,
   output psd_entry_type pop_entry
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   psd_entry_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   logic do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/core/psd_front.sv @@
`timescale 1ns / 1ps

module psd_front
   import psd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   psd_req_if.sink       req_ch,
   input  logic          q_full,
   output logic          push,
   output psd_entry_type entry
);

   psd_phase_type phase_ff, phase_in, phase_cur;
   logic [4:0]    count_ff, count_in, count_cur;
   logic          swap_ff, swap_in, swap_cur;
   logic          nano_ff, nano_in, nano_cur;
   logic [127:0]  shift_ff, shift_in, shift_cur;
   logic [31:0]   left_ff, left_in, left_cur;

   logic          accept;
   logic          emit;
   logic [127:0]  hdr;
   logic [31:0]   magic;
   logic [31:0]   w_sec, w_frac, w_cap, w_len;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push         = accept && emit;

   // restart puts the state back to reset before this byte is parsed
   always_comb begin
      phase_cur = req_ch.restart ? PH_GLOBAL : phase_ff;
      count_cur = req_ch.restart ? '0 : count_ff;
      swap_cur  = req_ch.restart ? 1'b0 : swap_ff;
      nano_cur  = req_ch.restart ? 1'b0 : nano_ff;
      shift_cur = req_ch.restart ? '0 : shift_ff;
      left_cur  = req_ch.restart ? '0 : left_ff;
   end

   assign magic = shift_cur[31:0];
   assign hdr   = {req_ch.stream_byte, shift_cur[119:0]};
   assign w_sec  = swap_cur ? flip32(hdr[31:0])   : hdr[31:0];
   assign w_frac = swap_cur ? flip32(hdr[63:32])  : hdr[63:32];
   assign w_cap  = swap_cur ? flip32(hdr[95:64])  : hdr[95:64];
   assign w_len  = swap_cur ? flip32(hdr[127:96]) : hdr[127:96];

   always_comb begin
      phase_in = phase_cur;
      count_in = count_cur;
      swap_in  = swap_cur;
      nano_in  = nano_cur;
      shift_in = shift_cur;
      left_in  = left_cur;
      emit     = 1'b0;
      entry    = '0;

      unique case (phase_cur)
         PH_GLOBAL: begin
            if (count_cur < 5'd4) begin
               shift_in[{count_cur[1:0], 3'b000} +: 8] = req_ch.stream_byte;
            end
            count_in = count_cur + 1'b1;
            if (count_cur == GLOBAL_LAST_BYTE) begin
               count_in = '0;
               shift_in = '0;
               phase_in = PH_RECHDR;
               case (magic)
                  MAGIC_US_NATIVE: begin
                     swap_in = 1'b0;
                     nano_in = 1'b0;
                  end
                  MAGIC_US_SWAPPED: begin
                     swap_in = 1'b1;
                     nano_in = 1'b0;
                  end
                  MAGIC_NS_NATIVE: begin
                     swap_in = 1'b0;
                     nano_in = 1'b1;
                  end
                  MAGIC_NS_SWAPPED: begin
                     swap_in = 1'b1;
                     nano_in = 1'b1;
                  end
                  default: begin
                     phase_in   = PH_HALT;
                     emit       = 1'b1;
                     entry.kind = KIND_ERROR;
                  end
               endcase
            end
         end

         PH_RECHDR: begin
            if (count_cur[3:0] == RECHDR_LAST_BYTE) begin
               emit                  = 1'b1;
               entry.kind            = KIND_HEADER;
               entry.ts_sec          = w_sec;
               entry.ts_frac         = w_frac;
               entry.nano            = nano_cur;
               entry.wire_length     = w_len;
               entry.captured_length = w_cap;
               entry.last            = (w_cap == '0);
               count_in = '0;
               shift_in = '0;
               left_in  = w_cap;
               phase_in = (w_cap == '0) ? PH_RECHDR : PH_PAYLOAD;
            end else begin
               shift_in[{count_cur[3:0], 3'b000} +: 8] = req_ch.stream_byte;
               count_in = {1'b0, count_cur[3:0]} + 1'b1;
            end
         end

         PH_PAYLOAD: begin
            emit               = 1'b1;
            entry.kind         = KIND_PAYLOAD;
            entry.payload_byte = req_ch.stream_byte;
            if (left_cur != '0) begin
               left_in = left_cur - 1'b1;
            end
            if (left_cur <= 32'd1) begin
               entry.last = 1'b1;
               phase_in   = PH_RECHDR;
               count_in   = '0;
            end
         end

         PH_HALT: begin
            // drop everything until restart
         end

         default: begin
            phase_in = PH_HALT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_GLOBAL;
         count_ff <= '0;
         swap_ff  <= 1'b0;
         nano_ff  <= 1'b0;
         shift_ff <= '0;
         left_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         swap_ff  <= swap_in;
         nano_ff  <= nano_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
      end
   end

endmodule

@@ rtl/core/psd_back.sv @@
`timescale 1ns / 1ps

module psd_back
   import psd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  psd_entry_type q_entry,
   output logic          q_pop,
   psd_rsp_if.source     rsp_ch
);

   // stage A: both products
   logic          a_valid_ff;
   psd_kind_type  a_kind_ff;
   logic [61:0]   a_sec_ns_ff, a_sec_ns_in;
   logic [41:0]   a_frac_ns_ff, a_frac_ns_in;
   logic [31:0]   a_wire_ff, a_cap_ff;
   logic [7:0]    a_byte_ff;
   logic          a_last_ff;

   // stage B: output register
   logic          b_valid_ff;
   logic [1:0]    b_kind_ff;
   logic [63:0]   b_time_ff, b_time_in;
   logic [31:0]   b_wire_ff, b_cap_ff;
   logic [7:0]    b_byte_ff;
   logic          b_last_ff;

   logic b_load, a_load;

   assign b_load = !b_valid_ff || rsp_ch.ready;
   assign a_load = !a_valid_ff || b_load;
   assign q_pop  = q_valid && a_load;

   assign a_sec_ns_in  = 62'(q_entry.ts_sec) * 62'(NS_PER_SEC);
   assign a_frac_ns_in = q_entry.nano ? 42'(q_entry.ts_frac)
                                      : 42'(q_entry.ts_frac) * 42'(NS_PER_US);
   assign b_time_in    = 64'(a_sec_ns_ff) + 64'(a_frac_ns_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_load) begin
            a_valid_ff <= q_valid;
         end
         if (b_load) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_kind_ff    <= q_entry.kind;
         a_sec_ns_ff  <= a_sec_ns_in;
         a_frac_ns_ff <= a_frac_ns_in;
         a_wire_ff    <= q_entry.wire_length;
         a_cap_ff     <= q_entry.captured_length;
         a_byte_ff    <= q_entry.payload_byte;
         a_last_ff    <= q_entry.last;
      end
      if (b_load && a_valid_ff) begin
         b_kind_ff <= a_kind_ff;
         b_time_ff <= b_time_in;
         b_wire_ff <= a_wire_ff;
         b_cap_ff  <= a_cap_ff;
         b_byte_ff <= a_byte_ff;
         b_last_ff <= a_last_ff;
      end
   end

   assign rsp_ch.valid           = b_valid_ff;
   assign rsp_ch.kind            = b_kind_ff;
   assign rsp_ch.time_ns         = b_time_ff;
   assign rsp_ch.wire_length     = b_wire_ff;
   assign rsp_ch.captured_length = b_cap_ff;
   assign rsp_ch.payload_byte    = b_byte_ff;
   assign rsp_ch.last            = b_last_ff;

endmodule

@@ rtl/core/psd_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psd_checker
   import psd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [63:0] rsp_time_ns,
   input logic [31:0] rsp_wire_length,
   input logic [31:0] rsp_captured_length,
   input logic [7:0]  rsp_payload_byte,
   input logic        rsp_last
);

   // a stalled result holds
   `PSD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_time_ns) && $stable(rsp_payload_byte) && $stable(rsp_last))

   `PSD_ASSERT_MSG(a_kind_legal, clock, reset, rsp_valid |-> rsp_kind == KIND_HEADER || rsp_kind == KIND_PAYLOAD || rsp_kind == KIND_ERROR, "undefined result kind")

   `PSD_ASSERT_MSG(a_payload_clean, clock, reset, rsp_valid && rsp_kind == KIND_PAYLOAD |-> rsp_time_ns == '0 && rsp_wire_length == '0 && rsp_captured_length == '0, "payload item carries header fields")

   `PSD_ASSERT_MSG(a_error_clean, clock, reset, rsp_valid && rsp_kind == KIND_ERROR |-> rsp_time_ns == '0 && rsp_payload_byte == '0 && !rsp_last && rsp_captured_length == '0, "error item not clean")

   `PSD_ASSERT_MSG(a_header_last, clock, reset, rsp_valid && rsp_kind == KIND_HEADER |-> rsp_last == (rsp_captured_length == '0) && rsp_payload_byte == '0, "header last mark wrong")

endmodule

bind pcap_stream_deframer_unit psd_checker u_psd_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_kind            (rsp_ch.kind),
   .rsp_time_ns         (rsp_ch.time_ns),
   .rsp_wire_length     (rsp_ch.wire_length),
   .rsp_captured_length (rsp_ch.captured_length),
   .rsp_payload_byte    (rsp_ch.payload_byte),
   .rsp_last            (rsp_ch.last)
);

@@ verif/psd_deframe_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the parser state and checks
// every result item against the oldest prediction.
module psd_deframe_checker
   import psd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   psd_req_if   req_ch,
   psd_rsp_if   rsp_ch,
   output int   pending_count,
   output int   mismatch_count
);

   typedef struct packed {
      psd_kind_type kind;
      logic [63:0]  time_ns;
      logic [31:0]  wire_length;
      logic [31:0]  captured_length;
      logic [7:0]   payload_byte;
      logic         last;
   } deframed_item_type;

   psd_phase_type     phase;
   logic [4:0]        byte_count;
   logic              swap_order;
   logic              nano_precision;
   logic [127:0]      header_bytes;
   logic [31:0]       payload_left;
   deframed_item_type deframed_q [$];

   task automatic clear_parser();
      phase          = PH_GLOBAL;
      byte_count     = '0;
      swap_order     = 1'b0;
      nano_precision = 1'b0;
      header_bytes   = '0;
      payload_left   = '0;
   endtask

   // record header word in host order
   function automatic logic [31:0] header_word(input int idx);
      logic [31:0] w;
      w = header_bytes[32*idx +: 32];
      return swap_order ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
   endfunction

   task automatic deframe_byte(input logic [7:0] b, input logic restart);
      deframed_item_type item;
      logic [31:0]       magic;
      logic [31:0]       frac;
      logic [31:0]       cap;
      logic [3:0]        k;
      item = '0;
      if (restart)
         clear_parser();
      case (phase)
         PH_GLOBAL: begin
            if (byte_count < 5'd4)
               header_bytes[8*byte_count +: 8] = b;
            if (byte_count != 5'd23) begin
               byte_count = byte_count + 5'd1;
            end else begin
               byte_count   = '0;
               magic        = header_bytes[31:0];
               header_bytes = '0;
               phase        = PH_RECHDR;
               case (magic)
                  MAGIC_US_NATIVE: begin
                     swap_order = 1'b0; nano_precision = 1'b0;
                  end
                  MAGIC_US_SWAPPED: begin
                     swap_order = 1'b1; nano_precision = 1'b0;
                  end
                  MAGIC_NS_NATIVE: begin
                     swap_order = 1'b0; nano_precision = 1'b1;
                  end
                  MAGIC_NS_SWAPPED: begin
                     swap_order = 1'b1; nano_precision = 1'b1;
                  end
                  default: begin
                     phase     = PH_HALT;
                     item.kind = KIND_ERROR;
                     deframed_q.push_back(item);
                  end
               endcase
            end
         end
         PH_RECHDR: begin
            k = byte_count[3:0];
            header_bytes[8*k +: 8] = b;
            if (k != 4'd15) begin
               byte_count = {1'b0, k} + 5'd1;
            end else begin
               frac = header_word(1);
               cap  = header_word(2);
               item.kind            = KIND_HEADER;
               item.time_ns         = 64'(header_word(0)) * 64'd1000000000
                                    + (nano_precision ? 64'(frac) : 64'(frac) * 64'd1000);
               item.wire_length     = header_word(3);
               item.captured_length = cap;
               item.last            = (cap == 32'd0);
               byte_count   = '0;
               header_bytes = '0;
               if (cap != 32'd0) begin
                  payload_left = cap;
                  phase        = PH_PAYLOAD;
               end
               deframed_q.push_back(item);
            end
         end
         PH_PAYLOAD: begin
            item.kind         = KIND_PAYLOAD;
            item.payload_byte = b;
            if (payload_left != 32'd0)
               payload_left = payload_left - 32'd1;
            if (payload_left == 32'd0) begin
               item.last  = 1'b1;
               phase      = PH_RECHDR;
               byte_count = '0;
            end
            deframed_q.push_back(item);
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_result();
      deframed_item_type want;
      if (deframed_q.size() == 0) begin
         $display("%0t: unexpected result, expected none, got kind %0d last %0b",
                  $time, rsp_ch.kind, rsp_ch.last);
         mismatch_count++;
      end else begin
         want = deframed_q.pop_front();
         check_field("kind", 64'(want.kind), 64'(rsp_ch.kind));
         check_field("time_ns", want.time_ns, rsp_ch.time_ns);
         check_field("wire_length", 64'(want.wire_length), 64'(rsp_ch.wire_length));
         check_field("captured_length", 64'(want.captured_length),
                     64'(rsp_ch.captured_length));
         check_field("payload_byte", 64'(want.payload_byte), 64'(rsp_ch.payload_byte));
         check_field("last", 64'(want.last), 64'(rsp_ch.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         deframed_q.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            deframe_byte(req_ch.stream_byte, req_ch.restart);
         if (rsp_ch.valid && rsp_ch.ready)
            check_result();
      end
      pending_count = deframed_q.size();
   end

endmodule

@@ verif/pcap_stream_deframer_unit_tb.sv @@
`timescale 1ns / 1ps

// Top of the deframer bench: clock, reset, byte stimulus, result back-pressure
// and the verdict. All prediction and comparison lives in psd_deframe_checker.
module pcap_stream_deframer_unit_tb
   import psd_pkg::*;
();

   // directed part sends about 420 bytes; random part tops it up to about 600
   localparam int RANDOM_BYTES = 160;
   // leave a wide margin over the slowest run
   localparam int CYCLE_LIMIT  = 400000;

   localparam logic [31:0] GOOD_MAGICS [4] = '{MAGIC_US_NATIVE, MAGIC_US_SWAPPED,
                                               MAGIC_NS_NATIVE, MAGIC_NS_SWAPPED};

   logic clock;
   logic reset;
   int   pending_count;
   int   mismatch_count;
   int   cycle_count;
   int   bytes_sent;
   bit   count_bytes;
   bit   send_gaps_on;
   bit   recv_stalls_on;
   bit   file_swapped;   // record words of the current file go out MSB first

   psd_req_if req_ch ();
   psd_rsp_if rsp_ch ();

   pcap_stream_deframer_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   psd_deframe_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .pending_count  (pending_count),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the handshake hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side: a fresh random stall per item, or none while
   // stalls are switched off. Ready changes only on the falling edge.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = recv_stalls_on ? $urandom_range(0, 19) : 0;
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // One byte item: optional gap, then hold valid until the block takes it.
   // Valid stays high across back-to-back items.
   task automatic send_byte(input logic [7:0] b, input logic restart);
      int gap;
      gap = send_gaps_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.stream_byte = b;
      req_ch.restart     = restart;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      if (count_bytes)
         bytes_sent++;
   endtask

   // Sender holds off until every predicted result has come out.
   task automatic wait_for_drain();
      req_ch.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Global header, magic stored little-endian. n_bytes < 24 cuts it short.
   task automatic send_file_header(input logic [31:0] magic, input logic restart,
                                   input int n_bytes);
      file_swapped = (magic == MAGIC_US_SWAPPED) || (magic == MAGIC_NS_SWAPPED);
      for (int i = 0; i < n_bytes; i++) begin
         if (i < 4)
            send_byte(magic[8*i +: 8], (i == 0) ? restart : 1'b0);
         else
            send_byte(8'($urandom), 1'b0);
      end
   endtask

   // Record header in the file's byte order, then payload. hdr_bytes < 16 or
   // pay_bytes < cap leaves the record truncated.
   task automatic send_record(input logic [31:0] sec, input logic [31:0] frac,
                              input logic [31:0] cap, input logic [31:0] len,
                              input int hdr_bytes, input int pay_bytes);
      logic [31:0] words [4];
      logic [31:0] w;
      int          j;
      words = '{sec, frac, cap, len};
      for (int i = 0; i < hdr_bytes; i++) begin
         w = words[i / 4];
         j = i % 4;
         send_byte(file_swapped ? w[8*(3-j) +: 8] : w[8*j +: 8], 1'b0);
      end
      if (hdr_bytes == 16)
         repeat (pay_bytes) send_byte(8'($urandom), 1'b0);
   endtask

   // bytes the block ignores after a bad magic
   task automatic send_halted_noise(input int n);
      count_bytes = 1'b0;
      repeat (n) send_byte(8'($urandom), 1'b0);
      count_bytes = 1'b1;
   endtask

   initial begin
      logic [31:0] magic;
      logic [31:0] cap;
      int          roll;
      int          n_recs;
      int          hdr;
      int          pay;
      bit          truncate;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.stream_byte = '0;
      req_ch.restart     = 1'b0;
      count_bytes        = 1'b1;
      send_gaps_on       = 1'b0;
      recv_stalls_on     = 1'b0;
      file_swapped       = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed ----
      // first file straight out of reset, no restart mark
      send_file_header(MAGIC_US_NATIVE, 1'b0, 24);
      send_record(32'd0, 32'd0, 32'd0, 32'd0, 16, 0);                 // empty record
      send_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 16, 1);
      send_record(32'd7, 32'd999999, 32'd3, 32'd64, 16, 3);

      send_gaps_on   = 1'b1;
      recv_stalls_on = 1'b1;
      send_file_header(MAGIC_US_SWAPPED, 1'b1, 24);
      send_record(32'h1234_5678, 32'd999999, 32'd2, 32'd60, 16, 2);

      send_file_header(MAGIC_NS_NATIVE, 1'b1, 24);
      send_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1500, 16, 0);
      send_record(32'd1, 32'd999999999, 32'd1, 32'd1, 16, 1);

      // swapped nanosecond file whose record is cut in the payload
      send_file_header(MAGIC_NS_SWAPPED, 1'b1, 24);
      send_record(32'hA5A5_5A5A, 32'd12345, 32'd4, 32'd4, 16, 2);

      // huge capture length, cut after three bytes
      send_file_header(MAGIC_US_NATIVE, 1'b1, 24);
      send_record(32'd2, 32'd3, 32'hFFFF_FFFF, 32'd0, 16, 3);

      // restart in the middle of a record header
      send_file_header(MAGIC_NS_NATIVE, 1'b1, 24);
      send_record(32'd5, 32'd6, 32'd8, 32'd8, 7, 0);

      // restart in the middle of a global header
      send_file_header(MAGIC_US_SWAPPED, 1'b1, 10);

      // bad magic one bit off, then bytes that must be ignored,
      // including what looks like a fresh header without restart
      send_gaps_on   = 1'b0;
      recv_stalls_on = 1'b0;
      send_file_header(MAGIC_US_NATIVE ^ 32'h0000_0001, 1'b1, 24);
      count_bytes = 1'b0;
      send_file_header(MAGIC_US_NATIVE, 1'b0, 24);
      count_bytes = 1'b1;
      send_file_header(32'h0000_0000, 1'b1, 24);
      send_halted_noise(3);

      // back to a good file after the halt
      send_file_header(MAGIC_NS_SWAPPED, 1'b1, 24);
      send_record(32'h0000_0001, 32'h0000_0001, 32'd1, 32'd2, 16, 1);
      wait_for_drain();

      // ---- random ----
      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         // switch idling per file so some files run gap-free
         send_gaps_on   = ($urandom_range(0, 3) != 0);
         recv_stalls_on = ($urandom_range(0, 3) != 0);
         roll = $urandom_range(0, 19);
         if (roll < 2) begin
            magic = (roll == 0) ? $urandom
                                : GOOD_MAGICS[$urandom_range(0, 3)]
                                  ^ (32'd1 << $urandom_range(0, 31));
            send_file_header(magic, 1'b1, 24);
            send_halted_noise($urandom_range(0, 6));
         end else if (roll == 2) begin
            send_file_header(GOOD_MAGICS[$urandom_range(0, 3)], 1'b1, $urandom_range(1, 23));
         end else begin
            send_file_header(GOOD_MAGICS[$urandom_range(0, 3)], 1'b1, 24);
            n_recs = $urandom_range(1, 6);
            for (int r = 0; r < n_recs; r++) begin
               roll = $urandom_range(0, 9);
               if (roll < 2)
                  cap = 32'd0;
               else if (roll < 8)
                  cap = $urandom_range(1, 8);
               else
                  cap = $urandom_range(9, 40);
               truncate = (r == n_recs - 1) && ($urandom_range(0, 7) == 0);
               hdr = (truncate && $urandom_range(0, 1) == 1) ? $urandom_range(1, 15) : 16;
               pay = (truncate && hdr == 16 && cap != 0) ? $urandom_range(0, cap - 1) : cap;
               send_record($urandom,
                           ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 999999999),
                           cap,
                           ($urandom_range(0, 1) == 1) ? cap : $urandom,
                           hdr, pay);
            end
            if ($urandom_range(0, 24) == 0)
               wait_for_drain();
         end
      end

      // ---- drain and verdict ----
      req_ch.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      // give stray results time to come out of the pipeline
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
